// ----- src/gbe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared constants, command and status codes and control types of the
// gap buffer line editor.
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int TAB_STOP_DEF = 8;

    localparam int ACTION_W = 3;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int WIDTH_W  = 14;
    localparam int STATUS_W = 2;

    localparam logic [CHAR_W-1:0]  TAB_CHAR  = 8'd9;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 14'd16383;

    localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BACKSPACE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MOVE_LEFT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MOVE_RIGHT = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_MEASURE    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_EFFECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic clear;
        logic en;
    } meas_ctl_t;

endpackage
`default_nettype wire

// ----- src/gbe_text_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_text_mem
// Text store: one write port, one read port, registered read data that
// holds until the next read.
// ----------------------------------------------------------------------------
module gbe_text_mem #(
    parameter int DEPTH = gbe_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [gbe_pkg::CHAR_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [gbe_pkg::CHAR_W-1:0] rd_data
);

    logic [gbe_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- src/gbe_width_acc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_width_acc
// Display width accumulator: adds one column per byte, a tab jumps to the
// next tab stop; the reported width saturates.
// ----------------------------------------------------------------------------
module gbe_width_acc #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEF,
    parameter int TAB_STOP = gbe_pkg::TAB_STOP_DEF
) (
    input  wire logic                        clk,
    input  wire gbe_pkg::meas_ctl_t          ctl,
    input  wire logic [gbe_pkg::CHAR_W-1:0]  char_in,
    output logic      [gbe_pkg::WIDTH_W-1:0] width
);

    localparam int WW_RAW = $clog2(CAPACITY * TAB_STOP + 1);
    localparam int WW     = (WW_RAW > gbe_pkg::WIDTH_W) ? WW_RAW : gbe_pkg::WIDTH_W + 1;
    localparam int CW     = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    logic [WW-1:0] w_reg;
    logic [WW-1:0] w_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [CW:0]   col_inc;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + (CW+1)'(1);
        w_next   = w_reg;
        col_next = col_reg;
        if (ctl.clear)
        begin
            w_next   = '0;
            col_next = '0;
        end
        else if (ctl.en)
        begin
            if (char_in == gbe_pkg::TAB_CHAR)
            begin
                w_next   = w_reg + (WW'(TAB_STOP) - WW'(col_reg));
                col_next = '0;
            end
            else
            begin
                w_next   = w_reg + WW'(1);
                col_next = (col_inc == (CW+1)'(TAB_STOP)) ? '0 : col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        col_reg <= col_next;
    end

    assign width = (w_reg > WW'(gbe_pkg::WIDTH_MAX)) ? gbe_pkg::WIDTH_MAX
                                                     : w_reg[gbe_pkg::WIDTH_W-1:0];

endmodule
`default_nettype wire

// ----- src/gap_buffer_line_editor_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_core
// One-line text editor on a fixed-capacity gap buffer held in a single
// synchronous memory.
// ----------------------------------------------------------------------------
// One command is in flight at a time and each gives exactly one result.
// Insert, backspace, delete and boundary cases finish straight from the
// execute state; move left, move right and read first read the memory
// port and finish from the write-back or read-data state; measure walks
// only the text, one memory read per character. A new request is taken as
// soon as the previous result sits in the output register, even while that
// result is stalled. Inserting into a full buffer is refused with status
// full; the buffer needs no clearing after reset.
module gap_buffer_line_editor_core #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEF,
    parameter int TAB_STOP = gbe_pkg::TAB_STOP_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [gbe_pkg::ACTION_W-1:0] action,
    input  wire logic [gbe_pkg::CHAR_W-1:0]   char_in,
    input  wire logic [gbe_pkg::INDEX_W-1:0]  read_index,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [gbe_pkg::CHAR_W-1:0]   char_out,
    output logic      [gbe_pkg::COUNT_W-1:0]  char_count,
    output logic      [gbe_pkg::COUNT_W-1:0]  cursor_index,
    output logic      [gbe_pkg::WIDTH_W-1:0]  display_width,
    output logic      [gbe_pkg::STATUS_W-1:0] status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int XW = (PW > gbe_pkg::INDEX_W) ? PW : gbe_pkg::INDEX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_WB    = 3'd2;
    localparam logic [2:0] S_RDATA = 3'd3;
    localparam logic [2:0] S_MEAS  = 3'd4;

    localparam logic [PW-1:0] CAP = PW'(CAPACITY);

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [PW-1:0]                  gf_reg;
    logic [PW-1:0]                  gf_next;
    logic [PW-1:0]                  gl_reg;
    logic [PW-1:0]                  gl_next;
    logic [PW-1:0]                  scan_reg;
    logic [PW-1:0]                  scan_next;
    logic                           pend_reg;
    logic                           pend_next;
    logic [gbe_pkg::ACTION_W-1:0]   act_reg;
    logic [gbe_pkg::CHAR_W-1:0]     chr_reg;
    logic [gbe_pkg::INDEX_W-1:0]    idx_reg;
    logic                           out_valid_reg;

    logic                           in_accept;
    logic                           out_free;
    logic                           fin;
    logic [PW-1:0]                  gap_len;
    logic [PW-1:0]                  len;
    logic [PW-1:0]                  len_res;
    logic [PW-1:0]                  gf_dec;
    logic [PW-1:0]                  gl_dec;
    logic [PW-1:0]                  scan_inc;
    logic [XW-1:0]                  phys;
    logic                           in_range;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [gbe_pkg::CHAR_W-1:0]     wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [gbe_pkg::CHAR_W-1:0]     rd_data;
    logic [gbe_pkg::CHAR_W-1:0]     res_char;
    logic [gbe_pkg::STATUS_W-1:0]   res_status;
    logic [gbe_pkg::WIDTH_W-1:0]    res_meas;
    logic [gbe_pkg::WIDTH_W-1:0]    meas_width;
    gbe_pkg::meas_ctl_t             mctl;

    gbe_text_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbe_width_acc #(
        .CAPACITY (CAPACITY),
        .TAB_STOP (TAB_STOP)
    ) u_width (
        .clk     (clk),
        .ctl     (mctl),
        .char_in (rd_data),
        .width   (meas_width)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    assign gap_len  = gl_reg - gf_reg;
    assign len      = CAP - gap_len;
    assign gf_dec   = gf_reg - PW'(1);
    assign gl_dec   = gl_reg - PW'(1);
    assign scan_inc = scan_reg + PW'(1);
    assign in_range = XW'(idx_reg) < XW'(len);
    assign phys     = (XW'(idx_reg) < XW'(gf_reg)) ? XW'(idx_reg)
                                                   : XW'(idx_reg) + XW'(gap_len);
    assign len_res  = CAP - (gl_next - gf_next);

    always_comb
    begin
        state_next = state_reg;
        gf_next    = gf_reg;
        gl_next    = gl_reg;
        scan_next  = scan_reg;
        pend_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = gf_reg[AW-1:0];
        wr_data    = chr_reg;
        rd_en      = 1'b0;
        rd_addr    = gf_reg[AW-1:0];
        fin        = 1'b0;
        res_char   = '0;
        res_status = gbe_pkg::ST_OK;
        res_meas   = '0;
        mctl.clear = 1'b0;
        mctl.en    = pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (act_reg)
                    gbe_pkg::ACT_INSERT:
                    begin
                        fin = 1'b1;
                        if (gf_reg == gl_reg)
                        begin
                            res_status = gbe_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en   = out_free;
                            gf_next = gf_reg + PW'(1);
                        end
                    end
                    gbe_pkg::ACT_BACKSPACE:
                    begin
                        fin = 1'b1;
                        if (gf_reg != '0)
                        begin
                            gf_next = gf_dec;
                        end
                        else
                        begin
                            res_status = gbe_pkg::ST_NO_EFFECT;
                        end
                    end
                    gbe_pkg::ACT_DELETE:
                    begin
                        fin = 1'b1;
                        if (gl_reg != CAP)
                        begin
                            gl_next = gl_reg + PW'(1);
                        end
                        else
                        begin
                            res_status = gbe_pkg::ST_NO_EFFECT;
                        end
                    end
                    gbe_pkg::ACT_MOVE_LEFT:
                    begin
                        if (gf_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = gf_dec[AW-1:0];
                            state_next = S_WB;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            res_status = gbe_pkg::ST_NO_EFFECT;
                        end
                    end
                    gbe_pkg::ACT_MOVE_RIGHT:
                    begin
                        if (gl_reg != CAP)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = gl_reg[AW-1:0];
                            state_next = S_WB;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            res_status = gbe_pkg::ST_NO_EFFECT;
                        end
                    end
                    gbe_pkg::ACT_READ:
                    begin
                        if (in_range)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = phys[AW-1:0];
                            state_next = S_RDATA;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            res_status = gbe_pkg::ST_RANGE;
                        end
                    end
                    gbe_pkg::ACT_MEASURE:
                    begin
                        mctl.clear = 1'b1;
                        scan_next  = (gf_reg != '0) ? '0 : gl_reg;
                        state_next = S_MEAS;
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        res_status = gbe_pkg::ST_NO_EFFECT;
                    end
                endcase
            end
            S_WB:
            begin
                fin     = 1'b1;
                wr_en   = out_free;
                wr_data = rd_data;
                if (act_reg == gbe_pkg::ACT_MOVE_LEFT)
                begin
                    wr_addr = gl_dec[AW-1:0];
                    gf_next = gf_dec;
                    gl_next = gl_dec;
                end
                else
                begin
                    wr_addr = gf_reg[AW-1:0];
                    gf_next = gf_reg + PW'(1);
                    gl_next = gl_reg + PW'(1);
                end
            end
            S_RDATA:
            begin
                fin      = 1'b1;
                res_char = rd_data;
            end
            S_MEAS:
            begin
                if (scan_reg != CAP)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[AW-1:0];
                    pend_next = 1'b1;
                    scan_next = (scan_inc == gf_reg) ? gl_reg : scan_inc;
                end
                else if (!pend_reg)
                begin
                    fin      = 1'b1;
                    res_meas = meas_width;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin && out_free)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gf_reg        <= '0;
            gl_reg        <= CAP;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (fin && out_free)
            begin
                gf_reg        <= gf_next;
                gl_reg        <= gl_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (in_accept)
        begin
            act_reg <= action;
            chr_reg <= char_in;
            idx_reg <= read_index;
        end
        if (fin && out_free)
        begin
            char_out      <= res_char;
            char_count    <= gbe_pkg::COUNT_W'(len_res);
            cursor_index  <= gbe_pkg::COUNT_W'(gf_next);
            display_width <= res_meas;
            status        <= res_status;
        end
    end

`ifndef SYNTH
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        gf_reg <= gl_reg && gl_reg <= CAP)
        else $error("gap bounds out of order");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != S_IDLE)
        else $error("request accepted but no command started");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status == gbe_pkg::ST_FULL
            |-> char_count == gbe_pkg::COUNT_W'(CAPACITY))
        else $error("full status with free space");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_EXEC || state_reg == S_WB)
        else $error("store write outside an edit step");
`endif

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gap_buffer_line_editor_core. A short scripted
// sequence covers the boundary commands, no-effect and range statuses. Random
// editing sessions then fill the line to capacity and drain it again. Every
// result is compared field by field with a scripted reply or a behavioral
// gap buffer in the bench, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbe_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int TAB_W        = TAB_STOP_DEF;
    localparam int SCRIPT_LEN   = 25;
    localparam int RANDOM_ITEMS = 1150;
    localparam int MIXED_ITEMS  = 80;
    localparam int EDGE_ITEMS   = 12;
    localparam int DRAIN_MIN    = 60;
    localparam int LONG_HOLD    = 200;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    typedef enum int {PH_MIXED, PH_FILL, PH_FULL_EDGE, PH_DRAIN} load_phase_t;

    // cumulative percent per action, columns in action code order
    localparam int unsigned ACTION_CUTS [4][8] = '{
        '{35, 45, 55, 67, 79, 93, 97, 100},
        '{94, 94, 94, 96, 97, 99, 100, 100},
        '{50, 50, 50, 60, 70, 95, 100, 100},
        '{15, 40, 65, 72, 79, 94, 99, 100}
    };

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  cursor;
        logic [WIDTH_W-1:0]  width;
        logic [STATUS_W-1:0] st;
    } reply_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        logic                typed;
        reply_t              want;
    } script_row_t;

    localparam reply_t NO_REPLY = '0;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action     = ACT_INSERT;
    logic [CHAR_W-1:0]   char_in    = '0;
    logic [INDEX_W-1:0]  read_index = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [CHAR_W-1:0]   char_out;
    logic [COUNT_W-1:0]  char_count;
    logic [COUNT_W-1:0]  cursor_index;
    logic [WIDTH_W-1:0]  display_width;
    logic [STATUS_W-1:0] status;

    bit [CHAR_W-1:0] line_mem [CAP];
    int unsigned     gap_lo = 0;
    int unsigned     gap_hi = CAP;
    reply_t          replies_due [$];
    reply_t          due;
    int              mismatch_count = 0;
    int              quiet_cycles = 0;

    gap_buffer_line_editor_core #(
        .CAPACITY (CAP),
        .TAB_STOP (TAB_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .char_in       (char_in),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_out      (char_out),
        .char_count    (char_count),
        .cursor_index  (cursor_index),
        .display_width (display_width),
        .status        (status)
    );

    always #5 clk = ~clk;

    function automatic int unsigned line_length();
        return CAP - (gap_hi - gap_lo);
    endfunction

    function automatic reply_t apply_edit(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                          logic [INDEX_W-1:0] idx);
        reply_t      r;
        int unsigned w;
        int unsigned phys;
        r = '0;
        r.st = ST_OK;
        case (act)
            ACT_INSERT:
            begin
                if (gap_lo >= gap_hi)
                    r.st = ST_FULL;
                else
                begin
                    line_mem[gap_lo] = ch;
                    gap_lo++;
                end
            end
            ACT_BACKSPACE:
            begin
                if (gap_lo > 0)
                    gap_lo--;
                else
                    r.st = ST_NO_EFFECT;
            end
            ACT_DELETE:
            begin
                if (gap_hi < CAP)
                    gap_hi++;
                else
                    r.st = ST_NO_EFFECT;
            end
            ACT_MOVE_LEFT:
            begin
                if (gap_lo > 0)
                begin
                    gap_lo--;
                    gap_hi--;
                    line_mem[gap_hi] = line_mem[gap_lo];
                end
                else
                    r.st = ST_NO_EFFECT;
            end
            ACT_MOVE_RIGHT:
            begin
                if (gap_hi < CAP)
                begin
                    line_mem[gap_lo] = line_mem[gap_hi];
                    gap_lo++;
                    gap_hi++;
                end
                else
                    r.st = ST_NO_EFFECT;
            end
            ACT_READ:
            begin
                if (idx < line_length())
                begin
                    phys = (idx < gap_lo) ? idx : idx + gap_hi - gap_lo;
                    r.ch = line_mem[phys];
                end
                else
                    r.st = ST_RANGE;
            end
            ACT_MEASURE:
            begin
                w = 0;
                for (int i = 0; i < CAP; i++)
                    if (i < gap_lo || i >= gap_hi)
                        w += (line_mem[i] == TAB_CHAR) ? TAB_W - w % TAB_W : 1;
                r.width = (w > WIDTH_MAX) ? WIDTH_MAX : w[WIDTH_W-1:0];
            end
            default:
                r.st = ST_NO_EFFECT;
        endcase
        r.count  = COUNT_W'(line_length());
        r.cursor = COUNT_W'(gap_lo);
        return r;
    endfunction

    function automatic reply_t reply_of(int unsigned count, int unsigned cursor,
                                        logic [STATUS_W-1:0] st);
        reply_t r;
        r = '0;
        r.count  = COUNT_W'(count);
        r.cursor = COUNT_W'(cursor);
        r.st     = st;
        return r;
    endfunction

    function automatic script_row_t script_row(int k);
        script_row_t s;
        case (k)
            0:  s = '{ACT_BACKSPACE,  8'h00, 10'd0,    1'b1, reply_of(0, 0, ST_NO_EFFECT)};
            1:  s = '{ACT_MOVE_LEFT,  8'h00, 10'd0,    1'b1, reply_of(0, 0, ST_NO_EFFECT)};
            2:  s = '{ACT_DELETE,     8'h00, 10'd0,    1'b1, reply_of(0, 0, ST_NO_EFFECT)};
            3:  s = '{ACT_MOVE_RIGHT, 8'h00, 10'd0,    1'b1, reply_of(0, 0, ST_NO_EFFECT)};
            4:  s = '{ACT_READ,       8'h00, 10'd0,    1'b1, reply_of(0, 0, ST_RANGE)};
            5:  s = '{ACT_READ,       8'h00, 10'd1023, 1'b1, reply_of(0, 0, ST_RANGE)};
            6:  s = '{ACT_MEASURE,    8'h00, 10'd0,    1'b1, reply_of(0, 0, ST_OK)};
            7:  s = '{ACT_UNUSED,     8'hFF, 10'd1023, 1'b1, reply_of(0, 0, ST_NO_EFFECT)};
            8:  s = '{ACT_INSERT,     8'h00, 10'd0,    1'b1, reply_of(1, 1, ST_OK)};
            9:  s = '{ACT_INSERT,     8'hFF, 10'd1023, 1'b1, reply_of(2, 2, ST_OK)};
            10: s = '{ACT_INSERT,     TAB_CHAR, 10'd0, 1'b1, reply_of(3, 3, ST_OK)};
            11: s = '{ACT_INSERT,     8'h41, 10'd0,    1'b0, NO_REPLY};
            12: s = '{ACT_MEASURE,    8'h00, 10'd0,    1'b0, NO_REPLY};
            13: s = '{ACT_READ,       8'h00, 10'd0,    1'b0, NO_REPLY};
            14: s = '{ACT_READ,       8'h00, 10'd1,    1'b0, NO_REPLY};
            15: s = '{ACT_READ,       8'h00, 10'd4,    1'b1, reply_of(4, 4, ST_RANGE)};
            16: s = '{ACT_MOVE_LEFT,  8'h00, 10'd0,    1'b0, NO_REPLY};
            17: s = '{ACT_MOVE_LEFT,  8'h00, 10'd0,    1'b0, NO_REPLY};
            18: s = '{ACT_READ,       8'h00, 10'd3,    1'b0, NO_REPLY};
            19: s = '{ACT_INSERT,     TAB_CHAR, 10'd0, 1'b0, NO_REPLY};
            20: s = '{ACT_MEASURE,    8'h00, 10'd0,    1'b0, NO_REPLY};
            21: s = '{ACT_MOVE_RIGHT, 8'h00, 10'd0,    1'b0, NO_REPLY};
            22: s = '{ACT_DELETE,     8'h00, 10'd0,    1'b0, NO_REPLY};
            23: s = '{ACT_BACKSPACE,  8'h00, 10'd0,    1'b0, NO_REPLY};
            default: s = '{ACT_READ,  8'h00, 10'd1023, 1'b0, NO_REPLY};
        endcase
        return s;
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_W-1:0] idx, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        char_in    <= ch;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic compare_field(input string label, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // request side
    initial
    begin
        script_row_t         row;
        reply_t              predicted;
        logic [ACTION_W-1:0] act;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        load_phase_t         phase;
        int unsigned         len;
        int                  r;
        int                  a;
        int                  n;
        int                  edge_left;
        int                  drained;
        bit                  reached_full;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < SCRIPT_LEN; k++)
        begin
            row = script_row(k);
            send_request(row.act, row.ch, row.idx, $urandom_range(0, 3));
            predicted = apply_edit(row.act, row.ch, row.idx);
            replies_due.push_back(row.typed ? row.want : predicted);
        end
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);

        n            = 0;
        edge_left    = EDGE_ITEMS;
        drained      = 0;
        reached_full = 1'b0;
        while (n < RANDOM_ITEMS || drained < DRAIN_MIN)
        begin
            if (n < MIXED_ITEMS)
                phase = PH_MIXED;
            else if (!reached_full)
                phase = PH_FILL;
            else if (edge_left > 0)
            begin
                phase = PH_FULL_EDGE;
                edge_left--;
            end
            else
            begin
                phase = PH_DRAIN;
                drained++;
            end

            r = $urandom_range(0, 99);
            for (a = 0; a < 7 && r >= ACTION_CUTS[phase][a]; a++)
                ;
            act = ACTION_W'(a);
            ch  = ($urandom_range(0, 7) == 0) ? TAB_CHAR : CHAR_W'($urandom_range(0, 255));
            len = line_length();
            if (phase == PH_FULL_EDGE)
            begin
                case ($urandom_range(0, 3))
                    0:       idx = '0;
                    1:       idx = '1;
                    2:       idx = INDEX_W'(len - 1);
                    default: idx = INDEX_W'($urandom_range(0, CAP - 1));
                endcase
            end
            else if (len > 0 && $urandom_range(0, 3) != 0)
                idx = INDEX_W'($urandom_range(0, len - 1));
            else
                idx = INDEX_W'($urandom_range(0, CAP - 1));

            send_request(act, ch, idx, ((n / 100) % 4 == 1) ? 0 : $urandom_range(0, 3));
            predicted = apply_edit(act, ch, idx);
            replies_due.push_back(predicted);
            n++;

            // line just became full: let everything drain before probing the limit
            if (!reached_full && line_length() == CAP)
            begin
                reached_full = 1'b1;
                in_valid <= 1'b0;
                while (replies_due.size() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side stall pattern
    initial
    begin
        int hold;
        int taken;

        taken = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken == 150 || taken == 900)
                hold = LONG_HOLD;
            else if ((taken / 100) % 4 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: expected no result, got count %0d cursor %0d status %0d",
                         $time, char_count, cursor_index, status);
                mismatch_count++;
            end
            else
            begin
                due = replies_due.pop_front();
                compare_field("char_out", due.ch, char_out);
                compare_field("char_count", due.count, char_count);
                compare_field("cursor_index", due.cursor, cursor_index);
                compare_field("display_width", due.width, display_width);
                compare_field("status", due.st, status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
`default_nettype wire
